// ===== rtl/bbfc_pkg.sv =====
package bbfc_pkg;

	localparam int FX_W = 32;
	localparam int SUM_W = 50;
	localparam int DVD_W = 48;
	localparam int QDEPTH_DEF = 2;

	typedef logic signed [FX_W-1:0] fx_t;
	typedef logic signed [SUM_W-1:0] acc_t;

	localparam fx_t FX_ONE = 32'sd65536;
	localparam fx_t FX_START = 32'sd98304;
	localparam fx_t FX_MARGIN = 32'sd6554;
	localparam acc_t ACC_MAX = 50'sd2147483647;
	localparam acc_t ACC_MIN = -50'sd2147483648;

	// matrix entry (row, col) lives at index {row, col}
	typedef struct packed {
		logic [15:0][FX_W-1:0] m;
		logic [2:0][FX_W-1:0] org;
		logic [2:0][FX_W-1:0] ext;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic acc_t sx50(input logic [FX_W-1:0] a);
		return acc_t'({{(SUM_W-FX_W){a[FX_W-1]}}, a});
	endfunction

	// floor(p / 65536), kept in accumulator width
	function automatic acc_t prod_shr(input logic signed [63:0] p);
		return acc_t'({{2{p[63]}}, p[63:16]});
	endfunction

	function automatic fx_t sat32(input acc_t x);
		fx_t r;
		if (x > ACC_MAX) begin
			r = 32'sh7fffffff;
		end else if (x < ACC_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = fx_t'(x[FX_W-1:0]);
		end
		return r;
	endfunction

endpackage

// ===== rtl/bbfc_front.sv =====
module bbfc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic [15:0][31:0] vp,
	input  logic in_valid,
	output logic in_stall,
	input  logic [63:0] model_col0_xy,
	input  logic [63:0] model_col0_zw,
	input  logic [63:0] model_col1_xy,
	input  logic [63:0] model_col1_zw,
	input  logic [63:0] model_col2_xy,
	input  logic [63:0] model_col2_zw,
	input  logic [63:0] model_col3_xy,
	input  logic [63:0] model_col3_zw,
	input  logic [63:0] box_origin_xy,
	input  logic signed [31:0] box_origin_z,
	input  logic [63:0] box_extent_xy,
	input  logic signed [31:0] box_extent_z,
	input  logic q_full,
	output logic push,
	output bbfc_pkg::job_t push_data
);

	logic busy_q;
	logic [4:0] cnt_q;
	logic [15:0][31:0] model_q;
	logic [15:0][31:0] m_q;
	logic [2:0][31:0] org_q;
	logic [2:0][31:0] ext_q;
	logic signed [3:0][63:0] prod_s1;
	logic vld_s1;
	logic [3:0] idx_s1;
	logic [3:0][63:0] cxy;
	logic [3:0][63:0] czw;
	logic accept;
	logic issue;
	logic [3:0] e;
	bbfc_pkg::acc_t sum;

	assign cxy = {model_col3_xy, model_col2_xy, model_col1_xy, model_col0_xy};
	assign czw = {model_col3_zw, model_col2_zw, model_col1_zw, model_col0_zw};
	assign accept = in_valid && !busy_q;
	assign in_stall = busy_q;
	assign issue = busy_q && !cnt_q[4];
	assign e = cnt_q[3:0];
	assign push = busy_q && cnt_q[4] && !vld_s1 && !q_full;
	assign push_data = '{m: m_q, org: org_q, ext: ext_q};

	always_comb begin
		sum = '0;
		for (int k = 0; k < 4; k++) begin
			sum = sum + bbfc_pkg::prod_shr(prod_s1[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (push) begin
				busy_q <= 1'b0;
			end else if (issue) begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < 4; c++) begin
				model_q[{2'd0, 2'(c)}] <= cxy[c][31:0];
				model_q[{2'd1, 2'(c)}] <= cxy[c][63:32];
				model_q[{2'd2, 2'(c)}] <= czw[c][31:0];
				model_q[{2'd3, 2'(c)}] <= czw[c][63:32];
			end
			org_q <= {box_origin_z, box_origin_xy[63:32], box_origin_xy[31:0]};
			ext_q <= {box_extent_z, box_extent_xy[63:32], box_extent_xy[31:0]};
		end
		for (int k = 0; k < 4; k++) begin
			prod_s1[k] <= $signed(vp[{e[3:2], 2'(k)}]) * $signed(model_q[{2'(k), e[1:0]}]);
		end
		idx_s1 <= e;
		if (vld_s1) begin
			m_q[idx_s1] <= bbfc_pkg::sat32(sum);
		end
	end

endmodule

// ===== rtl/bbfc_queue.sv =====
module bbfc_queue #(
	parameter int DEPTH = bbfc_pkg::QDEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  bbfc_pkg::job_t push_data,
	input  logic pop,
	output bbfc_pkg::job_t pop_data,
	output bbfc_pkg::q_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bbfc_pkg::job_t mem [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign stat.full = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/bbfc_div.sv =====
module bbfc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic done,
	output logic signed [31:0] quo
);

	localparam int DW = bbfc_pkg::DVD_W;

	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic [DW-1:0] dvd_q;
	logic [31:0] d_q;
	logic [31:0] rem_q;
	logic [32:0] rem_sh;
	logic ge;
	logic [31:0] mag_n;
	logic [31:0] mag_d;

	assign mag_n = num[31] ? 32'(-num) : 32'(num);
	assign mag_d = den[31] ? 32'(-den) : 32'(den);
	assign rem_sh = {rem_q, dvd_q[DW-1]};
	assign ge = rem_sh >= {1'b0, d_q};
	assign done = done_q;

	// saturate the magnitude back into signed 32 bits
	always_comb begin
		if (neg_q) begin
			if (dvd_q > DW'(64'h80000000)) begin
				quo = 32'sh80000000;
			end else begin
				quo = 32'(-dvd_q[31:0]);
			end
		end else begin
			if (dvd_q > DW'(64'h7fffffff)) begin
				quo = 32'sh7fffffff;
			end else begin
				quo = $signed(dvd_q[31:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle shifted into the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag_n, 16'h0000};
			d_q <= mag_d;
			rem_q <= '0;
			neg_q <= num[31] ^ den[31];
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem_sh - {1'b0, d_q}) : rem_sh[31:0];
			dvd_q <= {dvd_q[DW-2:0], ge};
		end
	end

endmodule

// ===== rtl/bbfc_back.sv =====
module bbfc_back (
	input  logic clk,
	input  logic arst_n,
	input  bbfc_pkg::job_t pop_data,
	input  bbfc_pkg::q_stat_t q_stat,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic visible
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PT = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_DIV0 = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;
	localparam logic [2:0] S_UPD = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] corner_q;
	logic [2:0] cnt_q;
	bbfc_pkg::job_t job_q;
	logic [2:0][31:0] p_q;
	logic [3:0][31:0] v_q;
	logic [2:0][31:0] mn_q;
	logic [2:0][31:0] mx_q;
	logic signed [2:0][63:0] prod_s1;
	logic vld_s1;
	logic [1:0] row_s1;
	logic out_valid_q;
	logic vis_q;
	logic issue;
	logic can_out;
	logic culled;
	logic div_start;
	logic [2:0] div_done;
	logic signed [2:0][31:0] quo;
	logic signed [31:0] den;
	bbfc_pkg::acc_t sum;
	logic [2:0][31:0] mn_nx;
	logic [2:0][31:0] mx_nx;
	logic [2:0][31:0] p_nx;

	assign pop = (state_q == S_IDLE) && !q_stat.empty;
	assign issue = (state_q == S_MUL) && !cnt_q[2];
	assign can_out = !out_valid_q || !out_stall;
	assign div_start = (state_q == S_DIV0);
	assign den = (v_q[3] == '0) ? 32'sd1 : $signed(v_q[3]);
	assign out_valid = out_valid_q;
	assign visible = vis_q;

	for (genvar k = 0; k < 3; k++) begin : g_div
		bbfc_div u_div (
			.clk(clk),
			.arst_n(arst_n),
			.start(div_start),
			.num($signed(v_q[k])),
			.den(den),
			.done(div_done[k]),
			.quo(quo[k])
		);
	end

	always_comb begin
		sum = bbfc_pkg::sx50(job_q.m[{row_s1, 2'd3}]);
		for (int k = 0; k < 3; k++) begin
			sum = sum + bbfc_pkg::prod_shr(prod_s1[k]);
		end
	end

	// corner order: x sign from bit 2, y from bit 1, z from bit 0
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (corner_q[2-k]) begin
				p_nx[k] = bbfc_pkg::sat32(bbfc_pkg::sx50(job_q.org[k]) -
					bbfc_pkg::sx50(job_q.ext[k]));
			end else begin
				p_nx[k] = bbfc_pkg::sat32(bbfc_pkg::sx50(job_q.org[k]) +
					bbfc_pkg::sx50(job_q.ext[k]));
			end
		end
	end

	// min/max fold with margin growth after each corner
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mn_nx[k] = bbfc_pkg::sat32(bbfc_pkg::sx50(
				($signed(quo[k]) < $signed(mn_q[k])) ? quo[k] : mn_q[k]) -
				bbfc_pkg::sx50(bbfc_pkg::FX_MARGIN));
			mx_nx[k] = bbfc_pkg::sat32(bbfc_pkg::sx50(
				($signed(quo[k]) > $signed(mx_q[k])) ? quo[k] : mx_q[k]) +
				bbfc_pkg::sx50(bbfc_pkg::FX_MARGIN));
		end
	end

	assign culled = ($signed(mn_q[2]) > bbfc_pkg::FX_ONE) || ($signed(mx_q[2]) < 32'sd0) ||
		($signed(mn_q[0]) > bbfc_pkg::FX_ONE) || ($signed(mx_q[0]) < -bbfc_pkg::FX_ONE) ||
		($signed(mn_q[1]) > bbfc_pkg::FX_ONE) || ($signed(mx_q[1]) < -bbfc_pkg::FX_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			corner_q <= '0;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if ((state_q == S_OUT) && can_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						corner_q <= '0;
						state_q <= S_PT;
					end
				end
				S_PT: begin
					cnt_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q[2]) begin
						state_q <= S_DIV0;
					end
				end
				S_DIV0: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done[0]) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					corner_q <= corner_q + 3'd1;
					state_q <= (corner_q == 3'd7) ? S_OUT : S_PT;
				end
				S_OUT: begin
					if (can_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_data;
			for (int k = 0; k < 3; k++) begin
				mn_q[k] <= bbfc_pkg::FX_START;
				mx_q[k] <= -bbfc_pkg::FX_START;
			end
		end
		if (state_q == S_PT) begin
			p_q <= p_nx;
		end
		for (int k = 0; k < 3; k++) begin
			prod_s1[k] <= $signed(job_q.m[{cnt_q[1:0], 2'(k)}]) * $signed(p_q[k]);
		end
		row_s1 <= cnt_q[1:0];
		if (vld_s1) begin
			v_q[row_s1] <= bbfc_pkg::sat32(sum);
		end
		if (state_q == S_UPD) begin
			mn_q <= mn_nx;
			mx_q <= mx_nx;
		end
		if ((state_q == S_OUT) && can_out) begin
			vis_q <= !culled;
		end
	end

endmodule

// ===== rtl/bounding_box_frustum_cull.sv =====
// channel   | handshake                    | payload
// ----------+------------------------------+----------------------------------
// input     | in_valid / in_stall          | model_col*, box_origin_*, box_extent_*
// result    | out_valid / out_stall        | visible
// config    | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// the front forms the combined matrix, then hands it to the queue;
// the back works one object at a time, corner by corner, bound by the three
// bit-serial dividers (48 steps each) shared over all eight corners
// arst_n clears control state and the view-projection registers
// in_stall is high while the front builds or queues a matrix; the back keeps
// working while a result waits on out_stall, until it has the next result ready
module bounding_box_frustum_cull #(
	parameter int QDEPTH = bbfc_pkg::QDEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [3:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [63:0] model_col0_xy,
	input  logic [63:0] model_col0_zw,
	input  logic [63:0] model_col1_xy,
	input  logic [63:0] model_col1_zw,
	input  logic [63:0] model_col2_xy,
	input  logic [63:0] model_col2_zw,
	input  logic [63:0] model_col3_xy,
	input  logic [63:0] model_col3_zw,
	input  logic [63:0] box_origin_xy,
	input  logic signed [31:0] box_origin_z,
	input  logic [63:0] box_extent_xy,
	input  logic signed [31:0] box_extent_z,
	output logic out_valid,
	input  logic out_stall,
	output logic visible
);

	// view-projection matrix, entry (row, col) at index {row, col}
	logic [15:0][31:0] vp_q;
	logic q_push;
	logic q_pop;
	bbfc_pkg::job_t q_in;
	bbfc_pkg::job_t q_out;
	bbfc_pkg::q_stat_t q_stat;

	assign cfg_ready = 1'b1;

	// config transaction: even index below 8 loads rows x,y of a column, odd loads rows z,w; index 8 and up is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q <= '0;
		end else if (cfg_valid && !cfg_index[3]) begin
			if (!cfg_index[0]) begin
				vp_q[{2'd0, cfg_index[2:1]}] <= cfg_data[31:0];
				vp_q[{2'd1, cfg_index[2:1]}] <= cfg_data[63:32];
			end else begin
				vp_q[{2'd2, cfg_index[2:1]}] <= cfg_data[31:0];
				vp_q[{2'd3, cfg_index[2:1]}] <= cfg_data[63:32];
			end
		end
	end

	// front: matrix product, one entry per cycle on four multipliers
	bbfc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.vp(vp_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.model_col0_xy(model_col0_xy),
		.model_col0_zw(model_col0_zw),
		.model_col1_xy(model_col1_xy),
		.model_col1_zw(model_col1_zw),
		.model_col2_xy(model_col2_xy),
		.model_col2_zw(model_col2_zw),
		.model_col3_xy(model_col3_xy),
		.model_col3_zw(model_col3_zw),
		.box_origin_xy(box_origin_xy),
		.box_origin_z(box_origin_z),
		.box_extent_xy(box_extent_xy),
		.box_extent_z(box_extent_z),
		.q_full(q_stat.full),
		.push(q_push),
		.push_data(q_in)
	);

	// short job queue decoupling the two halves
	bbfc_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_in),
		.pop(q_pop),
		.pop_data(q_out),
		.stat(q_stat)
	);

	// back: corner transform, perspective divide, min/max fold, verdict
	bbfc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_data(q_out),
		.q_stat(q_stat),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.visible(visible)
	);

	// an accepted transaction always occupies the front for its matrix build
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("front free right after accepting a transaction");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("job queue read while empty");

endmodule

// ===== tb/sv/tb_bounding_box_frustum_cull.sv =====
module tb_bounding_box_frustum_cull;
	timeunit 1ns;
	timeprecision 1ps;

	// one object: model matrix columns, then box centre and half sizes
	typedef struct {
		logic [63:0] col [8];
		logic [63:0] org_xy;
		logic signed [31:0] org_z;
		logic [63:0] ext_xy;
		logic signed [31:0] ext_z;
	} object_t;

	localparam int CFG_COUNT = 8;
	localparam int STALL_LIMIT = 20000;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] model_col0_xy = '0, model_col0_zw = '0, model_col1_xy = '0;
	logic [63:0] model_col1_zw = '0, model_col2_xy = '0, model_col2_zw = '0;
	logic [63:0] model_col3_xy = '0, model_col3_zw = '0;
	logic [63:0] box_origin_xy = '0;
	logic signed [31:0] box_origin_z = '0;
	logic [63:0] box_extent_xy = '0;
	logic signed [31:0] box_extent_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic visible;

	bounding_box_frustum_cull uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the view-projection matrix, [row][col]
	longint vp [4][4];

	object_t pending_objects [$];
	logic expected_visible [$];

	int error_count = 0;
	int visible_count = 0;
	int culled_count = 0;
	int object_count = 0;
	int idle_cycles = 0;
	bit quiet_phase = 1'b0;
	bit hold_sender = 1'b0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	task automatic add_object(input object_t o);
		pending_objects.insert(pending_objects.size(), o);
	endtask

	// ---------------- fixed-point helpers ----------------
	function automatic longint s32(input logic [31:0] w);
		return longint'(signed'(w));
	endfunction

	function automatic longint clamp32(input longint x);
		if (x > S32_MAX) begin
			return S32_MAX;
		end
		if (x < S32_MIN) begin
			return S32_MIN;
		end
		return x;
	endfunction

	// q16.16 product with floor rounding (arithmetic shift)
	function automatic longint qmul(input longint a, input longint b);
		longint p;
		p = a * b;
		return p >>> 16;
	endfunction

	// visibility of one object under the current view-projection
	function automatic logic predict_visible(input object_t o);
		longint mdl [4][4];
		longint cm [4][4];
		longint org [3], ext [3], lo [3], hi [3], p [3], v [4];
		longint acc, q, t;
		bit neg;
		for (int c = 0; c < 4; c++) begin
			mdl[0][c] = s32(o.col[2*c][31:0]);
			mdl[1][c] = s32(o.col[2*c][63:32]);
			mdl[2][c] = s32(o.col[2*c+1][31:0]);
			mdl[3][c] = s32(o.col[2*c+1][63:32]);
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				acc = 0;
				for (int k = 0; k < 4; k++) begin
					acc += qmul(vp[r][k], mdl[k][c]);
				end
				cm[r][c] = clamp32(acc);
			end
		end
		org[0] = s32(o.org_xy[31:0]);
		org[1] = s32(o.org_xy[63:32]);
		org[2] = longint'(o.org_z);
		ext[0] = s32(o.ext_xy[31:0]);
		ext[1] = s32(o.ext_xy[63:32]);
		ext[2] = longint'(o.ext_z);
		for (int k = 0; k < 3; k++) begin
			lo[k] = bbfc_pkg::FX_START;
			hi[k] = -longint'(bbfc_pkg::FX_START);
		end
		// corner bit 2 picks x sign, bit 1 y, bit 0 z; set bit means minus
		for (int cn = 0; cn < 8; cn++) begin
			for (int k = 0; k < 3; k++) begin
				neg = cn[2-k];
				p[k] = clamp32(neg ? org[k] - ext[k] : org[k] + ext[k]);
			end
			for (int r = 0; r < 4; r++) begin
				acc = cm[r][3];
				for (int k = 0; k < 3; k++) begin
					acc += qmul(cm[r][k], p[k]);
				end
				v[r] = clamp32(acc);
			end
			// zero w stands for the smallest positive value
			if (v[3] == 0) begin
				v[3] = 1;
			end
			for (int k = 0; k < 3; k++) begin
				q = clamp32((v[k] * 65536) / v[3]);
				t = (q < lo[k]) ? q : lo[k];
				lo[k] = clamp32(t - bbfc_pkg::FX_MARGIN);
				t = (q > hi[k]) ? q : hi[k];
				hi[k] = clamp32(t + bbfc_pkg::FX_MARGIN);
			end
		end
		if (lo[2] > bbfc_pkg::FX_ONE || hi[2] < 0 || lo[0] > bbfc_pkg::FX_ONE ||
				hi[0] < -longint'(bbfc_pkg::FX_ONE) || lo[1] > bbfc_pkg::FX_ONE ||
				hi[1] < -longint'(bbfc_pkg::FX_ONE)) begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [31:0] q16(input int whole);
		return 32'(whole) << 16;
	endfunction

	function automatic logic [63:0] pack2(input logic [31:0] lo_w, input logic [31:0] hi_w);
		return {hi_w, lo_w};
	endfunction

	// a word that is mostly tame, sometimes wild
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return '0;
			default: return 32'($signed($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	// identity model, box of half size 0.25 centred at z = 0.5
	function automatic object_t plain_object();
		object_t o;
		o.col[0] = pack2(q16(1), 0);
		o.col[1] = 0;
		o.col[2] = pack2(0, q16(1));
		o.col[3] = 0;
		o.col[4] = 0;
		o.col[5] = pack2(q16(1), 0);
		o.col[6] = 0;
		o.col[7] = pack2(0, q16(1));
		o.org_xy = 0;
		o.org_z = 32'sh8000;
		o.ext_xy = pack2(32'h4000, 32'h4000);
		o.ext_z = 32'sh4000;
		return o;
	endfunction

	// mostly plausible scenes, sometimes random noise in every bit
	function automatic object_t random_object();
		object_t o;
		o = plain_object();
		if ($urandom_range(0, 7) == 0) begin
			for (int i = 0; i < 8; i++) begin
				o.col[i] = {$urandom(), $urandom()};
			end
			o.org_xy = {$urandom(), $urandom()};
			o.org_z = $urandom();
			o.ext_xy = {$urandom(), $urandom()};
			o.ext_z = $urandom();
		end else begin
			for (int i = 0; i < 8; i++) begin
				if ($urandom_range(0, 2) == 0) begin
					o.col[i] = pack2(rand_word(), rand_word());
				end
			end
			o.org_xy = pack2(rand_word(), rand_word());
			o.org_z = rand_word();
			o.ext_xy = pack2(rand_word(), rand_word());
			o.ext_z = rand_word();
		end
		return o;
	endfunction

	// ---------------- driver ----------------
	// the object on the bus stays at the queue head until its transaction
	always @(posedge clk or negedge arst_n) begin
		object_t o;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				o = pending_objects.pop_front();
				expected_visible.insert(expected_visible.size(), predict_visible(o));
				object_count++;
			end
			if ((!in_valid || !in_stall) && pending_objects.size() > 0
					&& !hold_sender && (quiet_phase || $urandom_range(0, 99) >= 9)) begin
				o = pending_objects[0];
				in_valid <= 1'b1;
				model_col0_xy <= o.col[0];
				model_col0_zw <= o.col[1];
				model_col1_xy <= o.col[2];
				model_col1_zw <= o.col[3];
				model_col2_xy <= o.col[4];
				model_col2_zw <= o.col[5];
				model_col3_xy <= o.col[6];
				model_col3_zw <= o.col[7];
				box_origin_xy <= o.org_xy;
				box_origin_z <= o.org_z;
				box_extent_xy <= o.ext_xy;
				box_extent_z <= o.ext_z;
			end else if (!in_valid || !in_stall) begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_visible.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					if (visible !== expected_visible[0]) begin
						report_mismatch($sformatf("visible %b, expected %b", visible,
							expected_visible[0]));
					end
					void'(expected_visible.pop_front());
				end
				if (visible) begin
					visible_count++;
				end else begin
					culled_count++;
				end
			end
			out_stall <= !quiet_phase && ($urandom_range(0, 99) < 9);
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// ---------------- configuration ----------------
	task automatic write_reg(input int idx, input logic [63:0] value);
		int col;
		cfg_valid <= 1'b1;
		cfg_index <= 4'(idx);
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		// mirror the register in the predictor
		col = idx >> 1;
		if (idx[0] == 1'b0) begin
			vp[0][col] = s32(value[31:0]);
			vp[1][col] = s32(value[63:32]);
		end else begin
			vp[2][col] = s32(value[31:0]);
			vp[3][col] = s32(value[63:32]);
		end
		@(posedge clk);
	endtask

	// wait for every result, then for the pipeline to settle
	task automatic drain();
		while (pending_objects.size() != 0 || in_valid || expected_visible.size() != 0) begin
			@(posedge clk);
		end
		repeat (600) @(posedge clk);
	endtask

	task automatic load_identity();
		for (int c = 0; c < 4; c++) begin
			write_reg(2*c, c == 0 ? pack2(q16(1), 0) : c == 1 ? pack2(0, q16(1)) : 0);
			write_reg(2*c+1, c == 2 ? pack2(q16(1), 0) : c == 3 ? pack2(0, q16(1)) : 0);
		end
	endtask

	// ---------------- test sequence ----------------
	initial begin
		object_t o;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				vp[r][c] = 0;
			end
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset matrix is all zero: every w is zero and gets the smallest value
		add_object(plain_object());
		drain();

		// directed part under an identity view-projection
		load_identity();
		add_object(plain_object());
		o = plain_object();
		o.org_xy = pack2(q16(5), 0);
		add_object(o);
		o = plain_object();
		o.org_xy = pack2(0, q16(-5));
		add_object(o);
		o = plain_object();
		o.org_z = q16(-3);
		add_object(o);
		o = plain_object();
		o.org_z = q16(4);
		add_object(o);
		// saturating corner sums and extreme field values
		o = plain_object();
		o.org_xy = pack2(32'h7fffffff, 32'h80000000);
		o.ext_xy = pack2(32'h7fffffff, 32'h7fffffff);
		o.org_z = 32'sh7fffffff;
		o.ext_z = 32'sh80000000;
		add_object(o);
		o = plain_object();
		for (int i = 0; i < 8; i++) begin
			o.col[i] = '1;
		end
		o.org_xy = '1;
		o.ext_xy = '1;
		o.org_z = -1;
		o.ext_z = -1;
		add_object(o);
		o = plain_object();
		for (int i = 0; i < 8; i++) begin
			o.col[i] = {2{32'h7fffffff}};
		end
		add_object(o);
		o = plain_object();
		for (int i = 0; i < 8; i++) begin
			o.col[i] = {2{32'h80000000}};
		end
		add_object(o);
		// w of zero from the model's last row
		o = plain_object();
		o.col[7] = 0;
		add_object(o);
		// negative w flips the divisions
		o = plain_object();
		o.col[7] = pack2(0, q16(-1));
		add_object(o);
		// tiny w, huge quotients that saturate
		o = plain_object();
		o.col[7] = pack2(0, 32'h1);
		o.org_xy = pack2(q16(100), q16(-100));
		add_object(o);
		// wait until the block has drained, then hold the sender off with hold_sender
		drain();
		hold_sender = 1'b1;
		repeat (20) @(posedge clk);
		hold_sender = 1'b0;

		// random phases, each with a different view-projection
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: load_identity();
				1: for (int i = 0; i < CFG_COUNT; i++) write_reg(i, {2{32'h7fffffff}});
				2: for (int i = 0; i < CFG_COUNT; i++) write_reg(i, {2{32'h80000000}});
				3: for (int i = 0; i < CFG_COUNT; i++) write_reg(i, '1);
				default: for (int i = 0; i < CFG_COUNT; i++) begin
					write_reg(i, $urandom_range(0, 1) ? {$urandom(), $urandom()}
						: pack2(rand_word(), rand_word()));
				end
			endcase
			// in the last phase, a perspective-ish matrix replaces the random one
			if (phase == 5) begin
				load_identity();
				write_reg(5, pack2(q16(1), q16(1)));
			end
			quiet_phase = (phase == 4);
			for (int n = 0; n < (phase < 4 ? 100 : 275); n++) begin
				add_object(random_object());
			end
			drain();
		end
		quiet_phase = 1'b0;

		$display("covered %0d objects over 8 view-projection settings", object_count);
		$display("results: %0d visible, %0d culled, %0d mismatches", visible_count,
			culled_count, error_count);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bbfc_pkg.sv
rtl/bbfc_front.sv
rtl/bbfc_queue.sv
rtl/bbfc_div.sv
rtl/bbfc_back.sv
rtl/bounding_box_frustum_cull.sv
tb/sv/tb_bounding_box_frustum_cull.sv
